### sv/pftk_pkg.sv
`timescale 1ns / 1ps

package pftk_pkg;

  localparam int POS_W      = 24;
  localparam int RAD_W      = 23;
  localparam int TRIG_W     = 16;
  localparam int TRIG_FRAC  = 14;
  localparam int RATIO_FRAC = 16;
  localparam int GAIN_FRAC  = 12;
  localparam int FORCE_W    = 32;
  localparam int CFG_AW     = 2;
  localparam int CFG_DW     = 24;

  localparam int D_W        = POS_W + 2;    // signed position difference
  localparam int SQ_W       = 2 * POS_W;    // one squared axis
  localparam int D2_W       = SQ_W + 1;     // squared distance
  localparam int R2_W       = 2 * RAD_W;
  localparam int RAD_IN_W   = 64;           // sqrt radicand
  localparam int ROOT_W     = 32;
  localparam int SQ_REM_W   = ROOT_W + 2;
  localparam int SQ_STAGES  = ROOT_W / 2;   // two root bits per stage
  localparam int Q_W        = 31;           // distance, Q.8
  localparam int NUM_W      = 48;
  localparam int QUO_W      = 40;
  localparam int DIV_STAGES = QUO_W / 2;    // two quotient bits per stage

  localparam logic [15:0] UNIT = 16'd16384;
  localparam logic signed [31:0] ONE2 = 32'sd268435456;  // 1.0 in Q.28

  typedef enum logic [CFG_AW-1:0] {
    REG_BOX    = 2'd0,
    REG_RADIUS = 2'd1,
    REG_GAIN   = 2'd2,
    REG_TORQUE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [15:0] c1;
    logic signed [15:0] s1;
    logic signed [15:0] c2;
    logic signed [15:0] s2;
  } hdg_t;

  typedef struct packed {
    logic             hit;
    logic             neg_x;
    logic             neg_y;
    logic [POS_W-1:0] ax;
    logic [POS_W-1:0] ay;
    hdg_t             hdg;
  } side_t;

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
  } sq_t;

  typedef struct packed {
    logic [Q_W-1:0]   rem;
    logic [QUO_W-1:0] bits;
    logic [QUO_W-1:0] quo;
  } div_t;

  typedef struct packed {
    logic signed [15:0] p1x;
    logic signed [15:0] p1y;
    logic signed [15:0] p2x;
    logic signed [15:0] p2y;
  } pull_t;

  function automatic logic signed [D_W-1:0] fold(logic signed [D_W-1:0] d,
                                                 logic [POS_W-1:0] len);
    logic signed [D_W:0] dd;
    logic signed [D_W:0] ll;
    dd = {d, 1'b0};
    ll = $signed({3'b0, len});
    if (dd > ll) begin
      return d - $signed({2'b0, len});
    end else if (dd < -ll) begin
      return d + $signed({2'b0, len});
    end
    return d;
  endfunction

  function automatic sq_t sqrt_step(sq_t s, logic [1:0] b);
    logic [SQ_REM_W+1:0] t;
    logic [SQ_REM_W+1:0] c;
    sq_t o;
    t = {s.rem, b};
    c = {2'b0, s.root, 2'b01};
    if (t >= c) begin
      o.rem  = SQ_REM_W'(t - c);
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = t[SQ_REM_W-1:0];
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic div_t div_step(div_t s, logic [Q_W-1:0] den);
    logic [Q_W:0] t;
    div_t o;
    t = {s.rem, s.bits[QUO_W-1]};
    o.bits = {s.bits[QUO_W-2:0], 1'b0};
    if (t >= {1'b0, den}) begin
      o.rem = Q_W'(t - {1'b0, den});
      o.quo = {s.quo[QUO_W-2:0], 1'b1};
    end else begin
      o.rem = t[Q_W-1:0];
      o.quo = {s.quo[QUO_W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic signed [15:0] unit_of(logic [QUO_W-1:0] quo, logic neg);
    logic [15:0] m;
    m = (quo > QUO_W'(UNIT)) ? UNIT : quo[15:0];
    return neg ? $signed(16'(-m)) : $signed(m);
  endfunction

  // round to nearest, ties away from zero
  function automatic logic signed [63:0] round_shift(logic signed [63:0] v, int unsigned s);
    logic [63:0] mag;
    mag = v[63] ? 64'(-v) : 64'(v);
    mag = (mag + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [63:0] v);
    if (v > 64'sd32767) return 16'sh7FFF;
    if (v < -64'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

### sv/pair_force_torque_kernel_unit.sv
`timescale 1ns / 1ps

// Pair force and alignment kernel: takes one particle pair per clock while the output
// is not held and returns the minimum-image soft repulsive force on the first particle
// plus the alignment pulls on both; throughput is one pair per cycle while no result
// waits on out_ready. The depth comes from the square-root unit (32 root bits, two per
// stage) and the three parallel divider lanes (40 quotient bits, two per stage) that
// form the unit vector and the radius ratio. The whole pipeline holds while a result
// waits on out_ready; nothing is lost or repeated. Configuration registers are written
// through cfg_we/cfg_addr/cfg_wdata and must only change while the pipeline is empty.
module pair_force_torque_kernel_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pftk_pkg::CFG_AW-1:0]         cfg_addr,
  input  logic [pftk_pkg::CFG_DW-1:0]         cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pftk_pkg::POS_W-1:0]          in_first_x,
  input  logic [pftk_pkg::POS_W-1:0]          in_first_y,
  input  logic [pftk_pkg::POS_W-1:0]          in_second_x,
  input  logic [pftk_pkg::POS_W-1:0]          in_second_y,
  input  logic signed [pftk_pkg::TRIG_W-1:0]  in_first_cos,
  input  logic signed [pftk_pkg::TRIG_W-1:0]  in_first_sin,
  input  logic signed [pftk_pkg::TRIG_W-1:0]  in_second_cos,
  input  logic signed [pftk_pkg::TRIG_W-1:0]  in_second_sin,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_in_range,
  output logic signed [pftk_pkg::FORCE_W-1:0] out_force_x,
  output logic signed [pftk_pkg::FORCE_W-1:0] out_force_y,
  output logic signed [pftk_pkg::TRIG_W-1:0]  out_first_pull_x,
  output logic signed [pftk_pkg::TRIG_W-1:0]  out_first_pull_y,
  output logic signed [pftk_pkg::TRIG_W-1:0]  out_second_pull_x,
  output logic signed [pftk_pkg::TRIG_W-1:0]  out_second_pull_y
);

  localparam int S_DIFF = 1;
  localparam int S_FOLD = 2;
  localparam int S_SQR  = 3;
  localparam int S_D2   = 4;
  localparam int S_PREP = S_D2 + pftk_pkg::SQ_STAGES + 1;
  localparam int S_UNIT = S_PREP + pftk_pkg::DIV_STAGES + 1;
  localparam int S_PP1  = S_UNIT + 1;
  localparam int S_SUM1 = S_PP1 + 1;
  localparam int S_MAG  = S_SUM1 + 1;
  localparam int S_PP2  = S_MAG + 1;
  localparam int S_SUM2 = S_PP2 + 1;
  localparam int S_RND  = S_SUM2 + 1;
  localparam int LAST   = S_RND + 1;

  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_R = 2;

  // configuration
  logic [pftk_pkg::POS_W-1:0]  box_r;
  logic [pftk_pkg::RAD_W-1:0]  radius_r;
  logic signed [15:0]          gain_r;
  logic                        torque_r;
  logic [pftk_pkg::R2_W-1:0]   r2_r;

  logic [LAST:1] v_r;
  logic          adv;

  pftk_pkg::side_t side_r [1:LAST];

  logic signed [pftk_pkg::D_W-1:0] diff_x_r, diff_y_r, fold_x_r, fold_y_r;
  logic signed [2*pftk_pkg::D_W-1:0] sq_full_x, sq_full_y;
  logic [pftk_pkg::SQ_W-1:0] sq_x_r, sq_y_r;
  logic [pftk_pkg::D2_W-1:0] d2_sum, d2_r;
  logic d2_hit;

  pftk_pkg::sq_t                    sq_r [1:pftk_pkg::SQ_STAGES];
  logic [pftk_pkg::RAD_IN_W-1:0]    sv_r [1:pftk_pkg::SQ_STAGES];

  logic [pftk_pkg::Q_W-1:0]   q_end;
  logic [pftk_pkg::Q_W-1:0]   qp_r;
  logic [pftk_pkg::Q_W-1:0]   qd_r [1:pftk_pkg::DIV_STAGES];
  pftk_pkg::div_t             dp_r [0:2];
  pftk_pkg::div_t             dv_r [0:2][1:pftk_pkg::DIV_STAGES];
  logic [pftk_pkg::NUM_W-1:0] num_x, num_y, num_r;

  logic signed [15:0] ux_u_r, uy_u_r, ux_p_r, uy_p_r, ux_s_r, uy_s_r, ux_m_r, uy_m_r;
  logic signed [pftk_pkg::QUO_W:0] diff_r;
  logic signed [37:0] pp_lo_r;
  logic signed [35:0] pp_hi_r;
  logic signed [31:0] dot_r [0:3];
  logic signed [56:0] prod_r;
  logic signed [31:0] w1_r, w2_r;
  logic signed [44:0] fmag_r;
  logic signed [47:0] pm_r [0:3];
  logic signed [40:0] fl_x_r, fl_y_r;
  logic signed [36:0] fh_x_r, fh_y_r;
  logic signed [60:0] fp_x_r, fp_y_r;
  logic signed [47:0] fn_x_r, fn_y_r;
  pftk_pkg::pull_t    pull_a_r, pull_b_r, pull_c_r, pull_nxt;

  logic                                out_hit_r;
  logic signed [pftk_pkg::FORCE_W-1:0] out_fx_r, out_fy_r;
  pftk_pkg::pull_t                     out_pull_r;

  assign adv      = ~v_r[LAST] | out_ready;
  assign in_ready = adv;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r    <= 24'd926819;
      radius_r <= 23'd65536;
      gain_r   <= 16'sd0;
      torque_r <= 1'b1;
    end else if (cfg_we) begin
      case (pftk_pkg::cfg_reg_t'(cfg_addr))
        pftk_pkg::REG_BOX:    box_r    <= cfg_wdata;
        pftk_pkg::REG_RADIUS: radius_r <= cfg_wdata[pftk_pkg::RAD_W-1:0];
        pftk_pkg::REG_GAIN:   gain_r   <= $signed(cfg_wdata[15:0]);
        pftk_pkg::REG_TORQUE: torque_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    r2_r <= radius_r * radius_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[LAST-1:1], in_valid};
    end
  end

  // ---------------- side band ----------------
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[S_DIFF].hit    <= 1'b0;
      side_r[S_DIFF].neg_x  <= 1'b0;
      side_r[S_DIFF].neg_y  <= 1'b0;
      side_r[S_DIFF].ax     <= '0;
      side_r[S_DIFF].ay     <= '0;
      side_r[S_DIFF].hdg.c1 <= in_first_cos;
      side_r[S_DIFF].hdg.s1 <= in_first_sin;
      side_r[S_DIFF].hdg.c2 <= in_second_cos;
      side_r[S_DIFF].hdg.s2 <= in_second_sin;
    end
  end

  for (genvar k = 2; k <= LAST; k++) begin : g_side
    pftk_pkg::side_t side_nxt;
    always_comb begin
      side_nxt = side_r[k-1];
      if (k == S_SQR) begin
        side_nxt.neg_x = fold_x_r[pftk_pkg::D_W-1];
        side_nxt.neg_y = fold_y_r[pftk_pkg::D_W-1];
        side_nxt.ax    = fold_x_r[pftk_pkg::D_W-1] ?
                         pftk_pkg::POS_W'(-fold_x_r) : pftk_pkg::POS_W'(fold_x_r);
        side_nxt.ay    = fold_y_r[pftk_pkg::D_W-1] ?
                         pftk_pkg::POS_W'(-fold_y_r) : pftk_pkg::POS_W'(fold_y_r);
      end
      if (k == S_D2) begin
        side_nxt.hit = d2_hit;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[k] <= side_nxt;
      end
    end
  end

  // ---------------- separation and squared distance ----------------
  assign sq_full_x = fold_x_r * fold_x_r;
  assign sq_full_y = fold_y_r * fold_y_r;
  assign d2_sum    = {1'b0, sq_x_r} + {1'b0, sq_y_r};
  assign d2_hit    = (d2_sum != '0) && (d2_sum < {3'b0, r2_r});

  always_ff @(posedge clk) begin
    if (adv) begin
      diff_x_r <= $signed({2'b0, in_second_x}) - $signed({2'b0, in_first_x});
      diff_y_r <= $signed({2'b0, in_second_y}) - $signed({2'b0, in_first_y});
      fold_x_r <= pftk_pkg::fold(diff_x_r, box_r);
      fold_y_r <= pftk_pkg::fold(diff_y_r, box_r);
      sq_x_r   <= sq_full_x[pftk_pkg::SQ_W-1:0];
      sq_y_r   <= sq_full_y[pftk_pkg::SQ_W-1:0];
      d2_r     <= d2_sum;
    end
  end

  // ---------------- square root of d2 * 2^16 ----------------
  for (genvar j = 1; j <= pftk_pkg::SQ_STAGES; j++) begin : g_sqrt
    pftk_pkg::sq_t                 src, mid, res;
    logic [pftk_pkg::RAD_IN_W-1:0] srcv;
    if (j == 1) begin : g_first
      assign src  = '0;
      assign srcv = {2'b0, d2_r[45:0], 16'b0};
    end else begin : g_next
      assign src  = sq_r[j-1];
      assign srcv = sv_r[j-1];
    end
    assign mid = pftk_pkg::sqrt_step(src, srcv[63:62]);
    assign res = pftk_pkg::sqrt_step(mid, srcv[61:60]);
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_r[j] <= res;
        sv_r[j] <= {srcv[59:0], 4'b0};
      end
    end
  end

  // ---------------- divider operands ----------------
  assign q_end = sq_r[pftk_pkg::SQ_STAGES].root[pftk_pkg::Q_W-1:0];
  assign num_x = {2'b0, side_r[S_PREP-1].ax, 22'b0} + {18'b0, q_end[pftk_pkg::Q_W-1:1]};
  assign num_y = {2'b0, side_r[S_PREP-1].ay, 22'b0} + {18'b0, q_end[pftk_pkg::Q_W-1:1]};
  assign num_r = {1'b0, radius_r, 24'b0} + {18'b0, q_end[pftk_pkg::Q_W-1:1]};

  always_ff @(posedge clk) begin
    if (adv) begin
      qp_r <= q_end;
      dp_r[LANE_X] <= '{rem: {23'b0, num_x[47:40]}, bits: num_x[39:0], quo: '0};
      dp_r[LANE_Y] <= '{rem: {23'b0, num_y[47:40]}, bits: num_y[39:0], quo: '0};
      dp_r[LANE_R] <= '{rem: {23'b0, num_r[47:40]}, bits: num_r[39:0], quo: '0};
    end
  end

  for (genvar j = 1; j <= pftk_pkg::DIV_STAGES; j++) begin : g_div
    logic [pftk_pkg::Q_W-1:0] den;
    if (j == 1) begin : g_first
      assign den = qp_r;
    end else begin : g_next
      assign den = qd_r[j-1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        qd_r[j] <= den;
      end
    end
    for (genvar l = 0; l < 3; l++) begin : g_lane
      pftk_pkg::div_t src, mid, res;
      if (j == 1) begin : g_first
        assign src = dp_r[l];
      end else begin : g_next
        assign src = dv_r[l][j-1];
      end
      assign mid = pftk_pkg::div_step(src, den);
      assign res = pftk_pkg::div_step(mid, den);
      always_ff @(posedge clk) begin
        if (adv) begin
          dv_r[l][j] <= res;
        end
      end
    end
  end

  // ---------------- force and pull arithmetic ----------------
  always_comb begin
    pull_nxt.p1x = pftk_pkg::sat16(pftk_pkg::round_shift(64'(pm_r[0]), 29));
    pull_nxt.p1y = pftk_pkg::sat16(pftk_pkg::round_shift(64'(pm_r[1]), 29));
    pull_nxt.p2x = pftk_pkg::sat16(-pftk_pkg::round_shift(64'(pm_r[2]), 29));
    pull_nxt.p2y = pftk_pkg::sat16(-pftk_pkg::round_shift(64'(pm_r[3]), 29));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // unit vector and ratio - 1.0
      ux_u_r <= pftk_pkg::unit_of(dv_r[LANE_X][pftk_pkg::DIV_STAGES].quo,
                                  side_r[S_UNIT-1].neg_x);
      uy_u_r <= pftk_pkg::unit_of(dv_r[LANE_Y][pftk_pkg::DIV_STAGES].quo,
                                  side_r[S_UNIT-1].neg_y);
      diff_r <= $signed({1'b0, dv_r[LANE_R][pftk_pkg::DIV_STAGES].quo}) - 41'sd65536;

      // gain product split in two halves; heading dots
      pp_lo_r  <= gain_r * $signed({1'b0, diff_r[20:0]});
      pp_hi_r  <= gain_r * $signed(diff_r[40:21]);
      dot_r[0] <= ux_u_r * side_r[S_UNIT].hdg.c2;
      dot_r[1] <= uy_u_r * side_r[S_UNIT].hdg.s2;
      dot_r[2] <= ux_u_r * side_r[S_UNIT].hdg.c1;
      dot_r[3] <= uy_u_r * side_r[S_UNIT].hdg.s1;
      ux_p_r   <= ux_u_r;
      uy_p_r   <= uy_u_r;

      prod_r <= $signed({pp_hi_r, 21'b0}) + 57'(pp_lo_r);
      w1_r   <= pftk_pkg::ONE2 + dot_r[0] + dot_r[1];
      w2_r   <= pftk_pkg::ONE2 - (dot_r[2] + dot_r[3]);
      ux_s_r <= ux_p_r;
      uy_s_r <= uy_p_r;

      fmag_r   <= 45'(pftk_pkg::round_shift(64'(prod_r), pftk_pkg::GAIN_FRAC));
      pm_r[0]  <= w1_r * ux_s_r;
      pm_r[1]  <= w1_r * uy_s_r;
      pm_r[2]  <= w2_r * ux_s_r;
      pm_r[3]  <= w2_r * uy_s_r;
      ux_m_r   <= ux_s_r;
      uy_m_r   <= uy_s_r;

      // magnitude times unit, split at bit 24
      fl_x_r   <= $signed({1'b0, fmag_r[23:0]}) * ux_m_r;
      fh_x_r   <= $signed(fmag_r[44:24]) * ux_m_r;
      fl_y_r   <= $signed({1'b0, fmag_r[23:0]}) * uy_m_r;
      fh_y_r   <= $signed(fmag_r[44:24]) * uy_m_r;
      pull_a_r <= pull_nxt;

      fp_x_r   <= $signed({fh_x_r, 24'b0}) + 61'(fl_x_r);
      fp_y_r   <= $signed({fh_y_r, 24'b0}) + 61'(fl_y_r);
      pull_b_r <= pull_a_r;

      fn_x_r   <= 48'(-pftk_pkg::round_shift(64'(fp_x_r), pftk_pkg::TRIG_FRAC));
      fn_y_r   <= 48'(-pftk_pkg::round_shift(64'(fp_y_r), pftk_pkg::TRIG_FRAC));
      pull_c_r <= pull_b_r;

      // output register; non-interacting pairs read as all zero
      out_hit_r  <= side_r[S_RND].hit;
      out_fx_r   <= side_r[S_RND].hit ? pftk_pkg::sat32(64'(fn_x_r)) : '0;
      out_fy_r   <= side_r[S_RND].hit ? pftk_pkg::sat32(64'(fn_y_r)) : '0;
      out_pull_r <= (side_r[S_RND].hit && torque_r) ? pull_c_r : '0;
    end
  end

  assign out_valid         = v_r[LAST];
  assign out_in_range      = out_hit_r;
  assign out_force_x       = out_fx_r;
  assign out_force_y       = out_fy_r;
  assign out_first_pull_x  = out_pull_r.p1x;
  assign out_first_pull_y  = out_pull_r.p1y;
  assign out_second_pull_x = out_pull_r.p2x;
  assign out_second_pull_y = out_pull_r.p2y;

endmodule

### tb/pftk_checker.sv
`timescale 1ns / 1ps

module pftk_checker
  import pftk_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_AW-1:0]         cfg_addr,
  input  logic [CFG_DW-1:0]         cfg_wdata,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [POS_W-1:0]          in_first_x,
  input  logic [POS_W-1:0]          in_first_y,
  input  logic [POS_W-1:0]          in_second_x,
  input  logic [POS_W-1:0]          in_second_y,
  input  logic signed [TRIG_W-1:0]  in_first_cos,
  input  logic signed [TRIG_W-1:0]  in_first_sin,
  input  logic signed [TRIG_W-1:0]  in_second_cos,
  input  logic signed [TRIG_W-1:0]  in_second_sin,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic                      out_in_range,
  input  logic signed [FORCE_W-1:0] out_force_x,
  input  logic signed [FORCE_W-1:0] out_force_y,
  input  logic signed [TRIG_W-1:0]  out_first_pull_x,
  input  logic signed [TRIG_W-1:0]  out_first_pull_y,
  input  logic signed [TRIG_W-1:0]  out_second_pull_x,
  input  logic signed [TRIG_W-1:0]  out_second_pull_y,
  output int                        errors,
  output int                        pending,
  output int                        hits
);

  typedef struct packed {
    logic               hit;
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [15:0] p1x;
    logic signed [15:0] p1y;
    logic signed [15:0] p2x;
    logic signed [15:0] p2y;
  } pair_resp_t;

  pair_resp_t   resp_q[$];
  longint       box_len;
  longint       radius;
  longint       gain;
  logic         torque_on;

  function automatic longint rnd_shift(longint v, int s);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (64'sd1 <<< (s - 1))) >>> s;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic longint rnd_div(longint n, longint d);
    longint mag;
    mag = (n < 0) ? -n : n;
    mag = (mag + d / 2) / d;
    return (n < 0) ? -mag : mag;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint min_image(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
    longint d;
    d = longint'({40'd0, b}) - longint'({40'd0, a});
    if (2 * d > box_len) d = d - box_len;
    if (2 * d < -box_len) d = d + box_len;
    return d;
  endfunction

  function automatic pair_resp_t pair_response(
      logic [POS_W-1:0] ax, logic [POS_W-1:0] ay,
      logic [POS_W-1:0] bx, logic [POS_W-1:0] by,
      logic signed [15:0] c1, logic signed [15:0] s1,
      logic signed [15:0] c2, logic signed [15:0] s2);
    pair_resp_t r;
    longint dx, dy, d2, q, ux, uy, ratio, fmag, w1, w2;
    r = '0;
    dx = min_image(ax, bx);
    dy = min_image(ay, by);
    d2 = dx * dx + dy * dy;
    if (d2 == 0 || d2 >= radius * radius) return r;
    q = longint'(int_sqrt(longint'(d2) << 16));
    ux = clip(rnd_div(dx <<< 22, q), -16384, 16384);
    uy = clip(rnd_div(dy <<< 22, q), -16384, 16384);
    ratio = rnd_div(radius <<< 24, q);
    fmag = rnd_shift(gain * (ratio - 65536), 12);
    r.hit = 1'b1;
    r.fx = 32'(clip(-rnd_shift(fmag * ux, 14), -64'sd2147483648, 64'sd2147483647));
    r.fy = 32'(clip(-rnd_shift(fmag * uy, 14), -64'sd2147483648, 64'sd2147483647));
    if (torque_on) begin
      w1 = (64'sd1 <<< 28) + (ux * longint'(c2) + uy * longint'(s2));
      w2 = (64'sd1 <<< 28) - (ux * longint'(c1) + uy * longint'(s1));
      r.p1x = 16'(clip(rnd_shift(w1 * ux, 29), -32768, 32767));
      r.p1y = 16'(clip(rnd_shift(w1 * uy, 29), -32768, 32767));
      r.p2x = 16'(clip(-rnd_shift(w2 * ux, 29), -32768, 32767));
      r.p2y = 16'(clip(-rnd_shift(w2 * uy, 29), -32768, 32767));
    end
    return r;
  endfunction

  initial begin
    errors = 0;
    hits = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    pair_resp_t want;
    pair_resp_t got;
    if (!rst_n) begin
      box_len = 926819;
      radius = 65536;
      gain = 0;
      torque_on = 1'b1;
      resp_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_BOX:    box_len = longint'({40'd0, cfg_wdata});
          REG_RADIUS: radius = longint'({41'd0, cfg_wdata[RAD_W-1:0]});
          REG_GAIN:   gain = longint'($signed(cfg_wdata[15:0]));
          REG_TORQUE: torque_on = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = {out_in_range, out_force_x, out_force_y, out_first_pull_x,
               out_first_pull_y, out_second_pull_x, out_second_pull_y};
        if (resp_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected output transaction: %p", got);
        end else begin
          want = resp_q.pop_front();
          if (want.hit) hits++;
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch at %0t: expected %p, got %p", $realtime, want, got);
          end
        end
      end
      // sampled after the output side so a same-edge config write is already applied
      if (in_valid && in_ready)
        resp_q.insert(resp_q.size(),
                      pair_response(in_first_x, in_first_y, in_second_x, in_second_y,
                                    in_first_cos, in_first_sin, in_second_cos,
                                    in_second_sin));
    end
    pending = resp_q.size();
  end

endmodule

### tb/pair_force_torque_kernel_unit_test.sv
`timescale 1ns / 1ps

module pair_force_torque_kernel_unit_test;
  import pftk_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int FLUSH_CYCLES = 60;

  typedef struct {
    logic [POS_W-1:0]   ax, ay, bx, by;
    logic signed [15:0] c1, s1, c2, s2;
  } pair_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_AW-1:0]         cfg_addr;
  logic [CFG_DW-1:0]         cfg_wdata;
  logic                      in_valid;
  logic                      in_ready;
  logic [POS_W-1:0]          in_first_x, in_first_y, in_second_x, in_second_y;
  logic signed [TRIG_W-1:0]  in_first_cos, in_first_sin, in_second_cos, in_second_sin;
  logic                      out_valid;
  logic                      out_ready;
  logic                      out_in_range;
  logic signed [FORCE_W-1:0] out_force_x, out_force_y;
  logic signed [TRIG_W-1:0]  out_first_pull_x, out_first_pull_y;
  logic signed [TRIG_W-1:0]  out_second_pull_x, out_second_pull_y;

  int     errors, pending, hits;
  int     sent;
  bit     quiet;
  bit     long_hold_req;
  int     stall_left;
  int     idle_cycles;
  longint cur_box, cur_rad;

  pair_force_torque_kernel_unit u_top (.*);
  pftk_checker u_chk (.*);

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: random short stalls, one long hold on request, none when quiet
  initial stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      stall_left = 199;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // write enable stays high across back-to-back writes; the caller drops it
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DW-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == REG_BOX) cur_box = val;
    if (idx == REG_RADIUS) cur_rad = val;
  endtask

  task automatic set_phase(logic [23:0] box, logic [22:0] rad, logic [15:0] g, logic te);
    write_reg(REG_BOX, box);
    write_reg(REG_RADIUS, {1'b0, rad});
    write_reg(REG_GAIN, {8'd0, g});
    write_reg(REG_TORQUE, {23'd0, te});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // starts and ends on a rising edge; the final edge is the accepting one
  task automatic send_pair(pair_t p);
    if (!quiet && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_first_x <= p.ax;
    in_first_y <= p.ay;
    in_second_x <= p.bx;
    in_second_y <= p.by;
    in_first_cos <= p.c1;
    in_first_sin <= p.s1;
    in_second_cos <= p.c2;
    in_second_sin <= p.s2;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_heading();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  // mostly near pairs around the cutoff, some arbitrary positions anywhere
  function automatic pair_t rand_pair();
    pair_t p;
    longint span, dx, dy, bl;
    bl = (cur_box < 1) ? 1 : cur_box;
    p.c1 = rand_heading();
    p.s1 = rand_heading();
    p.c2 = rand_heading();
    p.s2 = rand_heading();
    if ($urandom_range(0, 4) == 0) begin
      p.ax = 24'($urandom);
      p.ay = 24'($urandom);
      p.bx = 24'($urandom);
      p.by = 24'($urandom);
    end else begin
      span = cur_rad + cur_rad / 4 + 1;
      dx = longint'($urandom_range(0, 32'(2 * span))) - span;
      dy = longint'($urandom_range(0, 32'(2 * span))) - span;
      p.ax = 24'(longint'($urandom) % bl);
      p.ay = 24'(longint'($urandom) % bl);
      p.bx = 24'(((longint'(p.ax) + dx) % bl + bl) % bl);
      p.by = 24'(((longint'(p.ay) + dy) % bl + bl) % bl);
    end
    return p;
  endfunction

  task automatic send_random(int n);
    repeat (n) send_pair(rand_pair());
  endtask

  task automatic send_fixed(logic [23:0] ax, logic [23:0] ay, logic [23:0] bx,
                            logic [23:0] by, logic signed [15:0] c1, logic signed [15:0] s1,
                            logic signed [15:0] c2, logic signed [15:0] s2);
    pair_t p;
    p.ax = ax; p.ay = ay; p.bx = bx; p.by = by;
    p.c1 = c1; p.s1 = s1; p.c2 = c2; p.s2 = s2;
    send_pair(p);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = REG_BOX;
    cfg_wdata = '0;
    in_valid = 1'b0;
    {in_first_x, in_first_y, in_second_x, in_second_y} = '0;
    {in_first_cos, in_first_sin, in_second_cos, in_second_sin} = '0;
    out_ready = 1'b0;
    quiet = 1'b0;
    long_hold_req = 1'b0;
    sent = 0;
    idle_cycles = 0;
    cur_box = 926819;
    cur_rad = 65536;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zero gain, torque on
    send_fixed(24'd100000, 24'd100000, 24'd130000, 24'd120000, 16384, 0, 0, 16384);
    send_fixed(24'd5000, 24'd5000, 24'd5000, 24'd5000, 16384, 0, -16384, 0);
    send_random(20);
    drain();

    set_phase(24'd926819, 23'd131072, 16'd4096, 1'b1);
    send_fixed(24'd0, 24'd0, 24'd131072, 24'd0, 16384, 0, 16384, 0);   // exactly at cutoff
    send_fixed(24'd0, 24'd0, 24'd131071, 24'd0, 16384, 0, -16384, 0);
    send_fixed(24'd0, 24'd0, 24'd926818, 24'd0, 0, 16384, 0, -16384);  // folds across box
    send_fixed(24'd926000, 24'd10, 24'd100, 24'd926800, -16384, 0, 0, 16384);
    send_fixed(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFF0, 24'hFFFFFF, 16384, 0, 16384, 0);
    send_fixed(24'd0, 24'd0, 24'd1, 24'd0, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000);
    send_fixed(24'd1000, 24'd1000, 24'd1000, 24'd1001, 16'sh8000, 16'sh7FFF, 16'sh7FFF,
               16'sh8000);
    send_fixed(24'd400000, 24'd400000, 24'd400000, 24'd400000, 16384, 0, 16384, 0);
    send_fixed(24'd0, 24'd0, 24'd50000, 24'd50000, 11585, 11585, -11585, 11585);
    long_hold_req = 1'b1;
    send_random(150);
    drain();

    set_phase(24'hFFFFFF, 23'h7FFFFF, 16'h8000, 1'b1);
    send_fixed(24'd0, 24'd0, 24'h7FFFFF, 24'd0, 16384, 0, 16384, 0);
    send_fixed(24'd0, 24'd0, 24'd1, 24'd1, -16384, 0, 16384, 0);
    send_random(120);
    drain();

    set_phase(24'd65536, 23'd1, 16'h7FFF, 1'b0);
    send_fixed(24'd0, 24'd0, 24'd1, 24'd0, 16384, 0, 16384, 0);
    send_random(60);
    drain();

    set_phase(24'd65536, 23'd40000, 16'h7FFF, 1'b0);
    send_random(80);
    drain();

    set_phase(24'd655360, 23'd196608, 16'($urandom), 1'b1);
    send_random(100);
    quiet = 1'b1;
    send_random(60);
    drain();

    $display("sent %0d pairs over six register settings, %0d of them in range",
             sent, hits);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
